// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// Cooperative task scheduler package
// Shared types, codes and default sizes for the task scheduler and its checker.
// ----------------------------------------------------------------------------
package cts_pkg;

   // Default table depth and tick length in milliseconds.
   localparam int MAX_TASKS_DEF = 16;
   localparam int TICK_STEP_DEF = 10;

   // At most this many tasks are dispatched by one dispatch command.
   localparam int RESULT_LIMIT = 16;

   // Command codes carried by req_opcode.
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_ADD      = 2'd2,
      OP_DELETE   = 2'd3
   } opcode_type;

   // Completion status of one command.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_TASK = 2'd2
   } status_type;

   // Sticky error record.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TOO_MANY = 2'd1,
      ERR_NO_TASK  = 2'd2
   } err_type;

   // One row of the task table.
   typedef struct packed {
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  pending;
      logic [7:0]  tag;
   } task_entry_type;

   localparam int ENTRY_W = $bits(task_entry_type);

endpackage

// ===== hw/rtl/cts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/cooperative_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Cooperative task scheduler
// Time-triggered task table with tick, dispatch, add and delete commands.
// ----------------------------------------------------------------------------
// Usage:
// Each command is one transfer on the req_ channel. The block answers with
// one or more transfers on the rsp_ channel; rsp_last_of_run marks the final
// one. Tick, add and delete give one acknowledgement. Dispatch gives one
// result per ready task in table order, or one acknowledgement if none ran.
// Tick and dispatch walk the whole table, and delete walks from the removed
// row to the end, through the task RAM, one entry per cycle on its single
// read and write port. Dispatch results then follow one per cycle while
// the receiver takes them. One command is worked on at a time.
// A new command is accepted while the last result still waits in the output
// register. When the receiver stalls, the output register holds and the
// block waits. Reset empties the table and clears the error record; the
// table RAM itself is not cleared, since only rows below the count are read.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler
   import cts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int TICK_STEP = TICK_STEP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_start_delay,
   input  logic [15:0] req_repeat_period,
   input  logic [7:0]  req_task_tag,
   input  logic [3:0]  req_task_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_run_tag,
   output logic [3:0]  rsp_run_position,
   output logic [1:0]  rsp_op_status,
   output logic [4:0]  rsp_tasks_present,
   output logic [1:0]  rsp_sticky_error,
   output logic        rsp_last_of_run
);

   localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW   = $clog2(MAX_TASKS + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;
   localparam int BW   = $clog2(RESULT_LIMIT);
   localparam int NW   = $clog2(RESULT_LIMIT + 1);

   localparam logic [15:0] TICK_W = 16'(TICK_STEP);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_EMIT
   } state_type;

   // Control and status registers.
   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   logic [CW-1:0]    del_idx_ff, del_idx_in;
   logic [CW-1:0]    total_ff, total_in;
   err_type          err_ff, err_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             rd_v_ff, rd_v_in;
   logic [CW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [BW-1:0]    out_ptr_ff, out_ptr_in;

   // Dispatch result buffer.
   logic [7:0]       buf_tag_ff [RESULT_LIMIT];
   logic [3:0]       buf_pos_ff [RESULT_LIMIT];
   logic             buf_we;
   logic [BW-1:0]    buf_widx;
   logic [7:0]       buf_wtag;
   logic [3:0]       buf_wpos;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_tag_ff, rsp_tag_in;
   logic [3:0]       rsp_pos_ff, rsp_pos_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [4:0]       rsp_present_ff, rsp_present_in;
   err_type          rsp_sticky_ff, rsp_sticky_in;
   logic             rsp_last_ff, rsp_last_in;

   // Task RAM ports.
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   task_entry_type   ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   task_entry_type   cur;
   task_entry_type   upd;
   task_entry_type   add_entry;
   logic             keep;
   logic             out_last;

   cts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign cur       = task_entry_type'(ram_rdata);
   assign out_last  = ((NW'(out_ptr_ff) + 1'b1) == n_ff);

   always_comb begin
      add_entry.delay   = req_start_delay;
      add_entry.period  = req_repeat_period;
      add_entry.pending = '0;
      add_entry.tag     = req_task_tag;
   end

   // Sequencer: accept, walk the table one row per cycle where the command needs it, then emit results.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      del_idx_in = del_idx_ff;
      total_in   = total_ff;
      err_in     = err_ff;
      status_in  = status_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_idx_in  = rd_idx_ff;
      rd_v_in    = 1'b0;
      wr_ptr_in  = wr_ptr_ff;
      n_in       = n_ff;
      out_ptr_in = out_ptr_ff;

      buf_we   = 1'b0;
      buf_widx = n_ff[BW-1:0];
      buf_wtag = cur.tag;
      buf_wpos = 4'(wr_ptr_ff);

      ram_we    = 1'b0;
      ram_waddr = wr_ptr_ff[AW-1:0];
      ram_wdata = cur;
      ram_raddr = rd_ptr_ff[AW-1:0];

      upd  = cur;
      keep = 1'b1;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_sticky_in  = rsp_sticky_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = opcode_type'(req_opcode);
               del_idx_in = CW'(req_task_index);
               status_in  = ST_OK;
               n_in       = '0;
               out_ptr_in = '0;
               rd_ptr_in  = '0;
               wr_ptr_in  = '0;
               case (opcode_type'(req_opcode))
                  OP_TICK, OP_DISPATCH: begin
                     state_in = S_WALK;
                  end
                  OP_ADD: begin
                     // Append at the end of the table, or flag a full table.
                     if (total_ff < CW'(MAX_TASKS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = total_ff[AW-1:0];
                        ram_wdata = add_entry;
                        total_in  = total_ff + 1'b1;
                     end else begin
                        err_in    = ERR_TOO_MANY;
                        status_in = ST_FULL;
                     end
                     state_in = S_EMIT;
                  end
                  OP_DELETE: begin
                     // Compaction starts at the removed row.
                     if (CMPW'(req_task_index) < CMPW'(total_ff)) begin
                        rd_ptr_in = CW'(req_task_index);
                        wr_ptr_in = CW'(req_task_index);
                        state_in  = S_WALK;
                     end else begin
                        err_in    = ERR_NO_TASK;
                        status_in = ST_NO_TASK;
                        state_in  = S_EMIT;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_WALK: begin
            // Issue the next row read.
            if (rd_ptr_ff < total_ff) begin
               rd_v_in   = 1'b1;
               rd_idx_in = rd_ptr_ff;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end

            // Update the row read last cycle and write it back compacted.
            if (rd_v_ff) begin
               case (op_ff)
                  OP_TICK: begin
                     if (cur.delay != '0) begin
                        upd.delay = (cur.delay > TICK_W) ? (cur.delay - TICK_W) : '0;
                     end else begin
                        if (cur.pending != 8'hFF) begin
                           upd.pending = cur.pending + 1'b1;
                        end
                        if (cur.period != '0) begin
                           upd.delay = cur.period;
                        end
                     end
                  end
                  OP_DISPATCH: begin
                     if ((cur.pending != '0) && (n_ff < NW'(RESULT_LIMIT))) begin
                        buf_we      = 1'b1;
                        n_in        = n_ff + 1'b1;
                        upd.pending = cur.pending - 1'b1;
                        keep        = (cur.period != '0);
                     end
                  end
                  OP_DELETE: begin
                     keep = (rd_idx_ff != del_idx_ff);
                  end
                  default: begin
                     keep = 1'b1;
                  end
               endcase
               if (keep) begin
                  ram_we    = 1'b1;
                  ram_wdata = upd;
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end

            // The write pointer ends at the new task count.
            if (!rd_v_ff && (rd_ptr_ff >= total_ff)) begin
               total_in = wr_ptr_ff;
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            // Load the output register whenever it is free or being drained.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = 5'(total_ff);
               rsp_sticky_in  = err_ff;
               if (n_ff == '0) begin
                  rsp_kind_in   = 1'b0;
                  rsp_tag_in    = '0;
                  rsp_pos_in    = '0;
                  rsp_status_in = status_ff;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rsp_kind_in   = 1'b1;
                  rsp_tag_in    = buf_tag_ff[out_ptr_ff];
                  rsp_pos_in    = buf_pos_ff[out_ptr_ff];
                  rsp_status_in = ST_OK;
                  rsp_last_in   = out_last;
                  if (out_last) begin
                     state_in = S_IDLE;
                  end else begin
                     out_ptr_in = out_ptr_ff + 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control registers and the registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         err_ff       <= ERR_NONE;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         err_ff       <= err_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      del_idx_ff     <= del_idx_in;
      status_ff      <= status_in;
      rd_ptr_ff      <= rd_ptr_in;
      rd_idx_ff      <= rd_idx_in;
      wr_ptr_ff      <= wr_ptr_in;
      n_ff           <= n_in;
      out_ptr_ff     <= out_ptr_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_sticky_ff  <= rsp_sticky_in;
      rsp_last_ff    <= rsp_last_in;
      if (buf_we) begin
         buf_tag_ff[buf_widx] <= buf_wtag;
         buf_pos_ff[buf_widx] <= buf_wpos;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_run_tag       = rsp_tag_ff;
   assign rsp_run_position  = rsp_pos_ff;
   assign rsp_op_status     = rsp_status_ff;
   assign rsp_tasks_present = rsp_present_ff;
   assign rsp_sticky_error  = rsp_sticky_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

// ===== hw/rtl/cts_checker.sv =====
// ----------------------------------------------------------------------------
// Cooperative task scheduler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cts_checker
   import cts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_run_tag,
   input logic [3:0]  rsp_run_position,
   input logic [1:0]  rsp_op_status,
   input logic [4:0]  rsp_tasks_present,
   input logic [1:0]  rsp_sticky_error,
   input logic        rsp_last_of_run
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_result_kind, rsp_run_tag, rsp_run_position, rsp_op_status,
                  rsp_tasks_present, rsp_sticky_error, rsp_last_of_run}))
      else $error("result changed while stalled");

   // Acknowledgements carry no tag and no position.
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> (rsp_run_tag == 8'd0) && (rsp_run_position == 4'd0))
      else $error("acknowledgement with nonzero tag or position");

   // A failed command ends with one acknowledgement.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_op_status != ST_OK) |-> rsp_last_of_run && !rsp_result_kind)
      else $error("error status on a dispatch result or a non-final result");

   // A failure is recorded in the sticky error at once.
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_op_status != ST_OK) |-> (rsp_sticky_error == rsp_op_status))
      else $error("sticky error does not match the failure");

endmodule

bind cooperative_task_scheduler cts_checker u_cts_checker (.*);

// ===== tb/tb_cooperative_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Cooperative task scheduler testbench
// Drives tick, dispatch, add and delete commands into the scheduler and checks
// every result against a task table tracked inside the bench. A directed
// opening covers the empty and full table, one-shot removal and bad deletes.
// Random traffic follows, with a long tick burst so that run counts saturate.
// Both channels idle at random, except for one stretch without idling.
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler;
   import cts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int CALM_FROM   = 1500;
   localparam int CALM_UNTIL  = 4500;

   // One command as it travels on the request channel.
   typedef struct packed {
      opcode_type  op;
      logic [15:0] sdelay;
      logic [15:0] period;
      logic [7:0]  tag;
      logic [3:0]  idx;
   } command_type;

   // One result as it travels on the response channel.
   typedef struct packed {
      logic        kind;
      logic [7:0]  tag;
      logic [3:0]  pos;
      status_type  status;
      logic [4:0]  present;
      err_type     sticky;
      logic        last;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_TICK;
   logic [15:0] req_start_delay = '0;
   logic [15:0] req_repeat_period = '0;
   logic [7:0]  req_task_tag = '0;
   logic [3:0]  req_task_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_run_tag;
   logic [3:0]  rsp_run_position;
   logic [1:0]  rsp_op_status;
   logic [4:0]  rsp_tasks_present;
   logic [1:0]  rsp_sticky_error;
   logic        rsp_last_of_run;

   command_type cmd_backlog[$];
   outcome_type due_results[$];
   int          mismatches = 0;
   int          clk_count = 0;
   int          quiet_cycles = 0;

   // Task table as the bench expects it to be.
   task_entry_type sched_table[MAX_TASKS_DEF];
   int             sched_count = 0;
   err_type        sched_err = ERR_NONE;

   cooperative_task_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .req_task_tag      (req_task_tag),
      .req_task_index    (req_task_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_run_tag       (rsp_run_tag),
      .rsp_run_position  (rsp_run_position),
      .rsp_op_status     (rsp_op_status),
      .rsp_tasks_present (rsp_tasks_present),
      .rsp_sticky_error  (rsp_sticky_error),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Random pauses on either side, switched off inside the calm window.
   function automatic bit take_break();
      if (clk_count >= CALM_FROM && clk_count < CALM_UNTIL) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 33;
   endfunction

   // Remove one table row and close the gap behind it.
   task automatic drop_task(input int pos);
      for (int i = pos; i + 1 < sched_count; i++) begin
         sched_table[i] = sched_table[i + 1];
      end
      sched_count--;
   endtask

   // Apply one command to the expected table and queue the results it causes.
   task automatic schedule_step(input command_type c);
      outcome_type batch[$];
      outcome_type ack;
      outcome_type run;
      int          i;
      ack = '0;
      ack.status = ST_OK;
      case (c.op)
         OP_TICK: begin
            for (i = 0; i < sched_count; i++) begin
               if (sched_table[i].delay != 0) begin
                  if (sched_table[i].delay > TICK_STEP_DEF) begin
                     sched_table[i].delay = 16'(sched_table[i].delay - TICK_STEP_DEF);
                  end else begin
                     sched_table[i].delay = '0;
                  end
               end else begin
                  if (sched_table[i].pending != 8'hFF) begin
                     sched_table[i].pending++;
                  end
                  if (sched_table[i].period != 0) begin
                     sched_table[i].delay = sched_table[i].period;
                  end
               end
            end
            batch.push_back(ack);
         end
         OP_DISPATCH: begin
            // A removed one-shot pulls the next row into its slot, so the
            // same position is looked at again.
            i = 0;
            while (i < sched_count && batch.size() < RESULT_LIMIT) begin
               if (sched_table[i].pending != 0) begin
                  run = '0;
                  run.kind = 1'b1;
                  run.tag = sched_table[i].tag;
                  run.pos = 4'(i);
                  run.status = ST_OK;
                  batch.push_back(run);
                  sched_table[i].pending--;
                  if (sched_table[i].period == 0) begin
                     drop_task(i);
                     continue;
                  end
               end
               i++;
            end
            if (batch.size() == 0) begin
               batch.push_back(ack);
            end
         end
         OP_ADD: begin
            if (sched_count < MAX_TASKS_DEF) begin
               sched_table[sched_count].delay = c.sdelay;
               sched_table[sched_count].period = c.period;
               sched_table[sched_count].pending = '0;
               sched_table[sched_count].tag = c.tag;
               sched_count++;
            end else begin
               sched_err = ERR_TOO_MANY;
               ack.status = ST_FULL;
            end
            batch.push_back(ack);
         end
         default: begin
            if (int'(c.idx) < sched_count) begin
               drop_task(int'(c.idx));
            end else begin
               sched_err = ERR_NO_TASK;
               ack.status = ST_NO_TASK;
            end
            batch.push_back(ack);
         end
      endcase
      foreach (batch[k]) begin
         batch[k].present = 5'(sched_count);
         batch[k].sticky = sched_err;
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) begin
         due_results.push_back(batch[k]);
      end
   endtask

   task automatic push_cmd(input opcode_type op, input logic [15:0] sdelay,
                           input logic [15:0] period, input logic [7:0] tag,
                           input logic [3:0] idx);
      command_type c;
      c.op = op;
      c.sdelay = sdelay;
      c.period = period;
      c.tag = tag;
      c.idx = idx;
      cmd_backlog.push_back(c);
   endtask

   // Mostly short delays and periods so that tasks fire often.
   task automatic push_random_cmd();
      int         r;
      opcode_type op;
      logic [15:0] sdelay;
      logic [15:0] period;
      logic [3:0]  idx;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         op = OP_TICK;
      end else if (r < 50) begin
         op = OP_DISPATCH;
      end else if (r < 82) begin
         op = OP_ADD;
      end else begin
         op = OP_DELETE;
      end
      r = $urandom_range(0, 9);
      sdelay = (r < 7) ? 16'($urandom_range(0, 40)) :
               (r < 9) ? 16'($urandom_range(0, 200)) : 16'($urandom);
      r = $urandom_range(0, 9);
      period = (r < 3) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 40)) : 16'($urandom);
      idx = $urandom_range(0, 1) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
      push_cmd(op, sdelay, period, 8'($urandom), idx);
   endtask

   // Request driver: holds each command until its transfer, then predicts it.
   always @(posedge clock) begin : driver
      command_type nxt;
      command_type sent;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sent.op = opcode_type'(req_opcode);
            sent.sdelay = req_start_delay;
            sent.period = req_repeat_period;
            sent.tag = req_task_tag;
            sent.idx = req_task_index;
            schedule_step(sent);
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && !take_break()) begin
               nxt = cmd_backlog.pop_front();
               req_opcode <= nxt.op;
               req_start_delay <= nxt.sdelay;
               req_repeat_period <= nxt.period;
               req_task_tag <= nxt.tag;
               req_task_index <= nxt.idx;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: every result transfer must match the oldest expectation.
   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type exp_res;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_result_kind, rsp_run_tag, rsp_run_position,
                   status_type'(rsp_op_status), rsp_tasks_present,
                   err_type'(rsp_sticky_error), rsp_last_of_run};
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing expected: kind=%0d tag=%0d pos=%0d",
                        $realtime, got.kind, got.tag, got.pos);
            end else begin
               exp_res = due_results.pop_front();
               if (got !== exp_res) begin
                  mismatches++;
                  $display("%0t: mismatch expected kind=%0d tag=%0d pos=%0d st=%0d n=%0d err=%0d last=%0d",
                           $realtime, exp_res.kind, exp_res.tag, exp_res.pos,
                           exp_res.status, exp_res.present, exp_res.sticky, exp_res.last);
                  $display("%0t: mismatch actual   kind=%0d tag=%0d pos=%0d st=%0d n=%0d err=%0d last=%0d",
                           $realtime, got.kind, got.tag, got.pos, got.status,
                           got.present, got.sticky, got.last);
               end
            end
         end
         rsp_ready <= !take_break();
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      clk_count <= clk_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Empty table: idle dispatch and a delete with nothing to remove.
      push_cmd(OP_DISPATCH, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'd0);
      // Field extremes, a delay below one tick and one of exactly one tick.
      push_cmd(OP_ADD, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);
      push_cmd(OP_ADD, 16'd5, 16'd10, 8'hA5, 4'd0);
      push_cmd(OP_ADD, 16'd10, 16'd0, 8'h5A, 4'd0);
      push_cmd(OP_TICK, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_TICK, 16'd0, 16'd0, 8'd0, 4'd0);
      // Two one-shots leave during one dispatch; the shifted rows are rechecked.
      push_cmd(OP_DISPATCH, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_DISPATCH, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'hF);
      // Fill the table, overflow it, then delete the last and first rows.
      for (int i = 0; i < MAX_TASKS_DEF - 2; i++) begin
         push_cmd(OP_ADD, 16'(i * 3), (i % 3 == 0) ? 16'd0 : 16'(i * 7),
                  8'(i * 17 + 1), 4'(i));
      end
      push_cmd(OP_ADD, 16'd1, 16'd1, 8'h3C, 4'd0);
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'hF);
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'd0);

      for (int i = 0; i < 40; i++) begin
         push_random_cmd();
      end
      // Long tick burst without dispatch so that run counts saturate.
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_DELETE, 16'd0, 16'd0, 8'd0, 4'd0);
      push_cmd(OP_ADD, 16'd0, 16'd0, 8'h77, 4'd0);
      push_cmd(OP_ADD, 16'd0, 16'd1, 8'h88, 4'd0);
      for (int i = 0; i < 260; i++) begin
         push_cmd(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
      end
      for (int i = 0; i < 3; i++) begin
         push_cmd(OP_DISPATCH, 16'd0, 16'd0, 8'd0, 4'd0);
      end
      for (int i = 0; i < 25; i++) begin
         push_random_cmd();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last command, then for its results, then drain.
      do @(posedge clock); while (cmd_backlog.size() != 0 || req_valid);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== cooperative_task_scheduler.f =====
hw/rtl/cts_pkg.sv
hw/rtl/cts_ram.sv
hw/rtl/cooperative_task_scheduler.sv
hw/rtl/cts_checker.sv
tb/tb_cooperative_task_scheduler.sv
